// File: hdl/vst_pkg.sv
// ----------------------------------------------------------------------------
// Version snapshot table package
// Sizes, operation and status codes, and the structs shared by the table
// and its cells.
// ----------------------------------------------------------------------------
package vst_pkg;

   localparam int MAX_ENTRIES = 16;
   localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
   localparam int OP_W        = 2;
   localparam int VER_W       = 32;
   localparam int HDL_W       = 32;
   localparam int STAT_W      = 2;
   localparam int ENTRY_W     = 5;

   typedef logic [OP_W-1:0]   op_type;
   typedef logic [STAT_W-1:0] status_type;

   localparam op_type OP_ADD    = op_type'(0);
   localparam op_type OP_LOOKUP = op_type'(1);
   localparam op_type OP_DELETE = op_type'(2);

   localparam status_type ST_OK        = status_type'(0);
   localparam status_type ST_NOT_FOUND = status_type'(1);
   localparam status_type ST_FULL      = status_type'(2);
   localparam status_type ST_NOT_ABOVE = status_type'(3);

   typedef struct packed {
      op_type           op;
      logic [VER_W-1:0] version;
      logic [HDL_W-1:0] handle;
   } cmd_type;

   typedef struct packed {
      logic [VER_W-1:0] version;
      logic [HDL_W-1:0] handle;
      logic             le;
      logic             occ;
   } link_type;

   typedef struct packed {
      logic upd;
      logic add_ok;
      logic occ;
      logic tail;
   } cell_ctrl_type;

endpackage

// File: hdl/vst_req_if.sv
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel that carries one table operation per beat.
// ----------------------------------------------------------------------------
interface vst_req_if;
   import vst_pkg::*;

   logic             valid;
   logic             ready;
   op_type           operation;
   logic [VER_W-1:0] version;
   logic [HDL_W-1:0] handle;

   modport source (output valid, output operation, output version, output handle,
                   input ready);
   modport sink   (input valid, input operation, input version, input handle,
                   output ready);
endinterface

// File: hdl/vst_rsp_if.sv
// ----------------------------------------------------------------------------
// Response channel
// Valid/ready channel that carries one operation result per beat.
// ----------------------------------------------------------------------------
interface vst_rsp_if;
   import vst_pkg::*;

   logic               valid;
   logic               ready;
   status_type         status;
   logic [HDL_W-1:0]   found_handle;
   logic [ENTRY_W-1:0] entry_count;

   modport source (output valid, output status, output found_handle,
                   output entry_count, input ready);
   modport sink   (input valid, input status, input found_handle,
                   input entry_count, output ready);
endinterface

// File: hdl/vst_cell.sv
// ----------------------------------------------------------------------------
// Table cell
// Holds one (version, handle) pair, loads the request's pair as the tail cell
// of an add, registers compare flags against the current request, and takes
// its upper neighbor's pair when a delete removes its own pair or one below.
// ----------------------------------------------------------------------------
module vst_cell (
   input  logic                   clock,
   input  vst_pkg::cmd_type       cmd,
   input  logic                   cmp_en,
   input  vst_pkg::cell_ctrl_type ctrl,
   input  vst_pkg::link_type      nbr_link,
   output vst_pkg::link_type      own_link,
   input  logic                   match_in,
   output logic                   match_out,
   output logic                   sel,
   output logic                   ge_hit
);
   import vst_pkg::*;

   logic [VER_W-1:0] ver_ff, ver_in;
   logic [HDL_W-1:0] hdl_ff, hdl_in;
   logic             le_ff, le_in;
   logic             ge_ff, ge_in;
   logic             hit_del;
   logic             hit_lk;

   always_comb begin
      le_in = le_ff;
      ge_in = ge_ff;
      if (cmp_en) begin
         le_in = (ver_ff <= cmd.version);
         ge_in = (ver_ff >= cmd.version);
      end
   end

   assign hit_del   = ctrl.occ & le_ff & ge_ff;
   assign hit_lk    = ctrl.occ & le_ff & ~(nbr_link.occ & nbr_link.le);
   assign match_out = match_in | hit_del;
   assign ge_hit    = ctrl.occ & ge_ff;
   assign sel       = ((cmd.op == OP_LOOKUP) & hit_lk) | ((cmd.op == OP_DELETE) & hit_del);

   always_comb begin
      ver_in = ver_ff;
      hdl_in = hdl_ff;
      if (ctrl.upd) begin
         if (cmd.op == OP_ADD && ctrl.add_ok && ctrl.tail) begin
            ver_in = cmd.version;
            hdl_in = cmd.handle;
         end else if (cmd.op == OP_DELETE && match_out && ctrl.occ) begin
            ver_in = nbr_link.version;
            hdl_in = nbr_link.handle;
         end
      end
   end

   always_ff @(posedge clock) begin
      ver_ff <= ver_in;
      hdl_ff <= hdl_in;
      le_ff  <= le_in;
      ge_ff  <= ge_in;
   end

   assign own_link = '{version: ver_ff, handle: hdl_ff, le: le_ff, occ: ctrl.occ};

endmodule

// File: hdl/version_snapshot_table_top.sv
// Each operation spends a compare state and an update state across the row
// of cells; its result enters the response slot at the end of the update
// state, and a new request beat is taken only as that state is left.
// A stalled response holds the update cycle until the response slot frees.
// Reset clears the entry count and the control state; cell contents are not
// cleared, and the table starts empty.
// ----------------------------------------------------------------------------
// Version snapshot table top level
// Ordered table of (version, handle) pairs kept in a row of cells, with add,
// lookup at or below a version, and delete of an exact version.
// ----------------------------------------------------------------------------
module version_snapshot_table_top (
   input logic  clock,
   input logic  reset,
   vst_req_if.sink   req_ch,
   vst_rsp_if.source rsp_ch
);
   import vst_pkg::*;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_CMP  = 2'd1;
   localparam logic [1:0] S_UPD  = 2'd2;

   logic [1:0]         state_ff, state_in;
   cmd_type            cmd_ff, cmd_in;
   logic [CNT_W-1:0]   count_ff, count_in, count_res;
   logic               rsp_valid_ff, rsp_valid_in;
   status_type         rsp_status_ff, rsp_status_in;
   logic [HDL_W-1:0]   rsp_handle_ff, rsp_handle_in;
   logic [ENTRY_W-1:0] rsp_count_ff, rsp_count_in;

   logic                        accept;
   logic                        advance;
   logic                        full;
   logic                        not_above;
   logic                        add_ok;
   logic [HDL_W-1:0]            sel_handle;
   logic [CNT_W+ENTRY_W-1:0]    count_ext;
   link_type                    link    [MAX_ENTRIES:0];
   logic [MAX_ENTRIES:0]        match;
   logic [MAX_ENTRIES-1:0]      sel_vec;
   logic [MAX_ENTRIES-1:0]      ge_vec;
   cell_ctrl_type               ctrl    [MAX_ENTRIES-1:0];

   assign advance      = (state_ff == S_UPD) && (!rsp_valid_ff || rsp_ch.ready);
   assign req_ch.ready = (state_ff == S_IDLE) || advance;
   assign accept       = req_ch.valid && req_ch.ready;

   assign full      = (count_ff == CNT_W'(MAX_ENTRIES));
   assign not_above = |ge_vec;
   assign add_ok    = !full && !not_above;

   assign link[MAX_ENTRIES] = '0;
   assign match[0]          = 1'b0;

   for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
      assign ctrl[i] = '{upd:    advance,
                         add_ok: add_ok,
                         occ:    (CNT_W'(i) < count_ff),
                         tail:   (CNT_W'(i) == count_ff)};

      vst_cell u_cell (
         .clock     (clock),
         .cmd       (cmd_ff),
         .cmp_en    (state_ff == S_CMP),
         .ctrl      (ctrl[i]),
         .nbr_link  (link[i+1]),
         .own_link  (link[i]),
         .match_in  (match[i]),
         .match_out (match[i+1]),
         .sel       (sel_vec[i]),
         .ge_hit    (ge_vec[i])
      );
   end

   always_comb begin
      sel_handle = '0;
      for (int i = 0; i < MAX_ENTRIES; i++) begin
         sel_handle = sel_handle | (link[i].handle & {HDL_W{sel_vec[i]}});
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:  if (accept) state_in = S_CMP;
         S_CMP:   state_in = S_UPD;
         S_UPD:   if (advance) state_in = accept ? S_CMP : S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   assign cmd_in = accept ? '{op: req_ch.operation, version: req_ch.version,
                              handle: req_ch.handle} : cmd_ff;

   always_comb begin
      count_res     = count_ff;
      rsp_status_in = ST_NOT_FOUND;
      rsp_handle_in = '0;
      unique case (cmd_ff.op)
         OP_ADD: begin
            if (full) begin
               rsp_status_in = ST_FULL;
            end else if (not_above) begin
               rsp_status_in = ST_NOT_ABOVE;
            end else begin
               rsp_status_in = ST_OK;
               count_res     = count_ff + CNT_W'(1);
            end
         end
         OP_LOOKUP: begin
            if (|sel_vec) begin
               rsp_status_in = ST_OK;
               rsp_handle_in = sel_handle;
            end
         end
         OP_DELETE: begin
            if (match[MAX_ENTRIES]) begin
               rsp_status_in = ST_OK;
               rsp_handle_in = sel_handle;
               count_res     = count_ff - CNT_W'(1);
            end
         end
         default: begin
            rsp_status_in = ST_NOT_FOUND;
         end
      endcase
   end

   assign count_ext    = {{ENTRY_W{1'b0}}, count_res};
   assign rsp_count_in = count_ext[ENTRY_W-1:0];
   assign count_in     = advance ? count_res : count_ff;
   assign rsp_valid_in = advance || (rsp_valid_ff && !rsp_ch.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
      if (advance) begin
         rsp_status_ff <= rsp_status_in;
         rsp_handle_ff <= rsp_handle_in;
         rsp_count_ff  <= rsp_count_in;
      end
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.status       = rsp_status_ff;
   assign rsp_ch.found_handle = rsp_handle_ff;
   assign rsp_ch.entry_count  = rsp_count_ff;

`ifndef SYNTHESIS
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_ENTRIES))
      else $error("Entry count exceeds the table size.");

   a_sel_onehot: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_UPD) |-> $onehot0(sel_vec))
      else $error("More than one cell selected for the result.");

   a_accept_cmp: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == S_CMP))
      else $error("Accepted beat did not enter the compare cycle.");

   a_delete_count: assert property (@(posedge clock) disable iff (reset)
      (advance && cmd_ff.op == OP_DELETE && match[MAX_ENTRIES])
      |=> (count_ff == $past(count_ff) - CNT_W'(1)))
      else $error("Delete did not shrink the table by one entry.");
`endif

endmodule
